@@ src/tcr_pkg.sv @@
// Shared types and constants of the thick circle ring rasterizer.
package tcr_pkg;

   localparam int COORD_W    = 11;
   localparam int THICK_W    = 8;
   localparam int COLOR_W    = 32;
   localparam int INDEX_W    = 20;
   localparam int RADIUS_W   = 12;
   localparam int SPAN_W     = RADIUS_W + 1;
   localparam int POS_W      = 14;
   localparam int OFS_W      = POS_W + 1;
   localparam int DIFF_W     = 13;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int RAD_W      = 28;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int CANVAS_WIDTH_DEF  = 1152;
   localparam int CANVAS_HEIGHT_DEF = 648;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [THICK_W-1:0] THICKNESS_RST  = THICK_W'(1);
   localparam logic [COORD_W-1:0] ORIGIN_X_RST   = COORD_W'(384);
   localparam logic [COORD_W-1:0] ORIGIN_Y_RST   = COORD_W'(324);
   localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = '0;

   localparam logic OP_START = 1'b0;
   localparam logic OP_SCAN  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_THICKNESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DRAW_COLOR = 2'd3;

   typedef enum logic {
      KIND_START,
      KIND_SCAN
   } req_kind_type;

   typedef struct packed {
      req_kind_type        kind;
      logic [COORD_W-1:0]  center_x;
      logic [COORD_W-1:0]  center_y;
      logic [COORD_W-1:0]  edge_x;
      logic [COORD_W-1:0]  edge_y;
   } queue_word_type;

   typedef struct packed {
      logic [THICK_W-1:0]  thickness;
      logic [COORD_W-1:0]  origin_x;
      logic [COORD_W-1:0]  origin_y;
      logic [COLOR_W-1:0]  draw_color;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_EMIT
   } back_state_type;

endpackage

@@ src/tcr_if.sv @@
// Handshake channels of the ring rasterizer: request, response and register write.
interface tcr_req_if;
   import tcr_pkg::*;
   logic               valid;
   logic               ready;
   logic               op;
   logic [COORD_W-1:0] center_x;
   logic [COORD_W-1:0] center_y;
   logic [COORD_W-1:0] edge_x;
   logic [COORD_W-1:0] edge_y;

   modport source (output valid, op, center_x, center_y, edge_x, edge_y, input ready);
   modport sink   (input valid, op, center_x, center_y, edge_x, edge_y, output ready);
endinterface

interface tcr_rsp_if;
   import tcr_pkg::*;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [INDEX_W-1:0] pixel_index;
   logic [COLOR_W-1:0] pixel_color;
   logic               last;

   modport source (output valid, hit, pixel_index, pixel_color, last, input ready);
   modport sink   (input valid, hit, pixel_index, pixel_color, last, output ready);
endinterface

interface tcr_csr_if;
   import tcr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/tcr_front.sv @@
// Request front end: classifies request words and buffers them in a short queue.
module tcr_front (
   input  logic                    clock,
   input  logic                    reset,
   tcr_req_if.sink                 req_ch,
   output logic                    q_valid,
   input  logic                    q_pop,
   output tcr_pkg::queue_word_type q_word
);
   import tcr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_word_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push;
   queue_word_type         push_word;

   assign req_ch.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (count_ff != '0);
   assign q_word       = entries_ff[rd_ptr_ff];

   always_comb begin
      push_word.kind     = (req_ch.op == OP_START) ? KIND_START : KIND_SCAN;
      push_word.center_x = req_ch.center_x;
      push_word.center_y = req_ch.center_y;
      push_word.edge_x   = req_ch.edge_x;
      push_word.edge_y   = req_ch.edge_y;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ src/tcr_sqrt.sv @@
// Floor square root, one result bit per cycle.
module tcr_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tcr_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [tcr_pkg::ROOT_W-1:0] root
);
   import tcr_pkg::*;

   localparam int REM_W = ROOT_W + 2;
   localparam int CAT_W = REM_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CAT_W-1:0]  cat_rem;
   logic [CAT_W-1:0]  cat_root;
   logic [CAT_W-1:0]  cat_diff;
   logic              ge;

   assign cat_rem  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign cat_root = CAT_W'({root_ff, 2'b01});
   assign ge       = (cat_rem >= cat_root);
   assign cat_diff = cat_rem - cat_root;
   assign done     = done_ff;
   assign root     = root_ff;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = ge ? cat_diff[REM_W-1:0] : cat_rem[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

@@ src/tcr_back.sv @@
// Back end: circle setup, scan walk, ring and canvas test, response register.
module tcr_back #(
   parameter int CANVAS_WIDTH  = tcr_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = tcr_pkg::CANVAS_HEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  tcr_pkg::queue_word_type q_word,
   input  tcr_pkg::cfg_type        cfg,
   tcr_rsp_if.source               rsp_ch
);
   import tcr_pkg::*;

   localparam int WIDTH_W = $clog2(CANVAS_WIDTH + 1);
   localparam int PROD_W  = OFS_W + WIDTH_W + 1;
   localparam int SUM_W   = PROD_W + 1;
   localparam logic signed [PROD_W-1:0] WIDTH_S = PROD_W'(CANVAS_WIDTH);
   localparam logic signed [SUM_W-1:0]  AREA_S  = SUM_W'(CANVAS_WIDTH * CANVAS_HEIGHT);

   back_state_type              state_ff, state_in;
   logic [COORD_W-1:0]          centre_x_ff, centre_x_in;
   logic [COORD_W-1:0]          centre_y_ff, centre_y_in;
   logic [RADIUS_W-1:0]         radius_ff, radius_in;
   logic signed [POS_W-1:0]     scan_x_ff, scan_x_in;
   logic signed [POS_W-1:0]     scan_y_ff, scan_y_in;
   logic                        busy_ff, busy_in;
   logic                        is_start_ff, is_start_in;
   logic [DIFF_W-1:0]           da_ff, da_in;
   logic [DIFF_W-1:0]           db_ff, db_in;
   logic [SQ_W-1:0]             sq_a_ff, sq_a_in;
   logic [SQ_W-1:0]             sq_b_ff, sq_b_in;
   logic signed [OFS_W-1:0]     ydiff_ff, ydiff_in;
   logic signed [OFS_W-1:0]     col_ff, col_in;
   logic signed [PROD_W-1:0]    row_ff, row_in;
   logic                        res_hit_ff, res_hit_in;
   logic [INDEX_W-1:0]          res_index_ff, res_index_in;
   logic                        res_last_ff, res_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff;
   logic [INDEX_W-1:0]          rsp_index_ff;
   logic [COLOR_W-1:0]          rsp_color_ff;
   logic                        rsp_last_ff;

   logic                        sqrt_start;
   logic [RAD_W-1:0]            sqrt_radicand;
   logic                        sqrt_done;
   logic [ROOT_W-1:0]           sqrt_root;

   logic signed [OFS_W-1:0]     x_ext, y_ext, cx_ext, cy_ext;
   logic signed [OFS_W-1:0]     span_ext, x_max, y_min, y_max;
   logic signed [OFS_W-1:0]     dxs, dys, dx_mag, dy_mag;
   logic [SPAN_W-1:0]           span;
   logic [SPAN_W-1:0]           new_span;
   logic signed [OFS_W-1:0]     new_span_ext;
   logic signed [OFS_W-1:0]     start_x, start_y;
   logic signed [OFS_W-1:0]     q_cx, q_cy;
   logic [COORD_W-1:0]          sdx, sdy;
   logic [ROOT_W-1:0]           gap;
   logic signed [SUM_W-1:0]     idx;
   logic                        ring_ok, in_canvas;
   logic                        out_free;

   tcr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign sqrt_start    = (state_ff == ST_SUM);
   assign sqrt_radicand = RAD_W'(sq_a_ff) + RAD_W'(sq_b_ff);

   // scan geometry from the current point and the current thickness, and the queue word's edge offsets
   always_comb begin
      x_ext    = OFS_W'(scan_x_ff);
      y_ext    = OFS_W'(scan_y_ff);
      cx_ext   = $signed(OFS_W'(centre_x_ff));
      cy_ext   = $signed(OFS_W'(centre_y_ff));
      span     = SPAN_W'(radius_ff) + SPAN_W'(cfg.thickness);
      span_ext = $signed(OFS_W'(span));
      x_max    = cx_ext + span_ext;
      y_min    = cy_ext - span_ext;
      y_max    = cy_ext + span_ext;
      dxs      = x_ext - cx_ext;
      dys      = y_ext - cy_ext;
      dx_mag   = dxs[OFS_W-1] ? -dxs : dxs;
      dy_mag   = dys[OFS_W-1] ? -dys : dys;
      sdx      = (q_word.center_x >= q_word.edge_x) ? q_word.center_x - q_word.edge_x
                                                    : q_word.edge_x - q_word.center_x;
      sdy      = (q_word.center_y >= q_word.edge_y) ? q_word.center_y - q_word.edge_y
                                                    : q_word.edge_y - q_word.center_y;
   end

   // circle setup once the radius root is known
   always_comb begin
      q_cx         = $signed(OFS_W'(centre_x_ff));
      q_cy         = $signed(OFS_W'(centre_y_ff));
      new_span     = SPAN_W'(sqrt_root[RADIUS_W-1:0]) + SPAN_W'(cfg.thickness);
      new_span_ext = $signed(OFS_W'(new_span));
      start_x      = q_cx - new_span_ext;
      start_y      = q_cy - new_span_ext;
   end

   // ring and canvas test of a scanned point
   always_comb begin
      gap       = (sqrt_root >= ROOT_W'(radius_ff)) ? sqrt_root - ROOT_W'(radius_ff)
                                                    : ROOT_W'(radius_ff) - sqrt_root;
      ring_ok   = (gap <= ROOT_W'(cfg.thickness));
      idx       = SUM_W'(row_ff) + SUM_W'(col_ff);
      in_canvas = !idx[SUM_W-1] && (idx < AREA_S);
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      centre_x_in  = centre_x_ff;
      centre_y_in  = centre_y_ff;
      radius_in    = radius_ff;
      scan_x_in    = scan_x_ff;
      scan_y_in    = scan_y_ff;
      busy_in      = busy_ff;
      is_start_in  = is_start_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      sq_a_in      = sq_a_ff;
      sq_b_in      = sq_b_ff;
      ydiff_in     = ydiff_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      res_hit_in   = res_hit_ff;
      res_index_in = res_index_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_word.kind == KIND_START) begin
                  centre_x_in = q_word.center_x;
                  centre_y_in = q_word.center_y;
                  da_in       = DIFF_W'(sdx);
                  db_in       = DIFF_W'(sdy);
                  is_start_in = 1'b1;
                  state_in    = ST_SQUARE;
               end else if (busy_ff) begin
                  da_in       = dx_mag[DIFF_W-1:0];
                  db_in       = dy_mag[DIFF_W-1:0];
                  col_in      = x_ext - $signed(OFS_W'(cfg.origin_x));
                  ydiff_in    = y_ext - $signed(OFS_W'(cfg.origin_y));
                  is_start_in = 1'b0;
                  res_last_in = 1'b0;
                  // walk: y inner, x outer; end of the box ends the scan
                  if (y_ext >= y_max) begin
                     if (x_ext >= x_max) begin
                        res_last_in = 1'b1;
                        busy_in     = 1'b0;
                     end else begin
                        scan_x_in = scan_x_ff + 1'b1;
                        scan_y_in = y_min[POS_W-1:0];
                     end
                  end else begin
                     scan_y_in = scan_y_ff + 1'b1;
                  end
                  state_in = ST_SQUARE;
               end else begin
                  res_hit_in   = 1'b0;
                  res_index_in = '0;
                  res_last_in  = 1'b1;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_SQUARE: begin
            sq_a_in  = SQ_W'(da_ff) * SQ_W'(da_ff);
            sq_b_in  = SQ_W'(db_ff) * SQ_W'(db_ff);
            row_in   = PROD_W'(ydiff_ff) * WIDTH_S;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               if (is_start_ff) begin
                  radius_in    = sqrt_root[RADIUS_W-1:0];
                  scan_x_in    = start_x[POS_W-1:0];
                  scan_y_in    = start_y[POS_W-1:0];
                  busy_in      = 1'b1;
                  res_hit_in   = 1'b0;
                  res_index_in = '0;
                  res_last_in  = 1'b0;
               end else begin
                  res_hit_in   = ring_ok && in_canvas;
                  res_index_in = (ring_ok && in_canvas) ? idx[INDEX_W-1:0] : '0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         centre_x_ff  <= '0;
         centre_y_ff  <= '0;
         radius_ff    <= '0;
         scan_x_ff    <= '0;
         scan_y_ff    <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         centre_x_ff  <= centre_x_in;
         centre_y_ff  <= centre_y_in;
         radius_ff    <= radius_in;
         scan_x_ff    <= scan_x_in;
         scan_y_ff    <= scan_y_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_start_ff  <= is_start_in;
      da_ff        <= da_in;
      db_ff        <= db_in;
      sq_a_ff      <= sq_a_in;
      sq_b_ff      <= sq_b_in;
      ydiff_ff     <= ydiff_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      res_hit_ff   <= res_hit_in;
      res_index_ff <= res_index_in;
      res_last_ff  <= res_last_in;
      if (state_ff == ST_EMIT && out_free) begin
         rsp_hit_ff   <= res_hit_ff;
         rsp_index_ff <= res_index_ff;
         rsp_color_ff <= res_hit_ff ? cfg.draw_color : '0;
         rsp_last_ff  <= res_last_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.pixel_index = rsp_index_ff;
   assign rsp_ch.pixel_color = rsp_color_ff;
   assign rsp_ch.last        = rsp_last_ff;

   a_root_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> state_ff == ST_ROOT)
      else $error("root result arrived outside the wait state");

   a_scan_end_marks_last: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy_ff)) |-> res_last_ff)
      else $error("scan ended without a last word");

   a_word_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response word loaded outside emit");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_index_ff == '0 && rsp_color_ff == '0))
      else $error("miss word carries index or color");

endmodule

@@ src/thick_circle_ring_rasterizer_top.sv @@
// Top level of the thick circle ring rasterizer: registers, front end, back end.
//
//   channel  dir  handshake      word
//   req_ch   in   valid/ready    op, center_x, center_y, edge_x, edge_y
//   rsp_ch   out  valid/ready    hit, pixel_index, pixel_color, last
//   csr_ch   in   valid/ready    index, data (ready always high)
//
// Start and scan words each pass through the square root unit, which forms its
// 14 result bits one at a time; a scan word while idle skips that unit.
// One word is worked on at a time; a two-word queue takes requests meanwhile.
// A pending response word stalls only the back end; the front keeps accepting
// until its queue is full.
// Reset is synchronous; after it the block is idle and registers hold defaults.
module thick_circle_ring_rasterizer_top #(
   parameter int CANVAS_WIDTH  = tcr_pkg::CANVAS_WIDTH_DEF,
   parameter int CANVAS_HEIGHT = tcr_pkg::CANVAS_HEIGHT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tcr_req_if.sink   req_ch,
   tcr_rsp_if.source rsp_ch,
   tcr_csr_if.sink   csr_ch
);
   import tcr_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           q_valid;
   logic           q_pop;
   queue_word_type q_word;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_THICKNESS:  cfg_in.thickness  = csr_ch.data[THICK_W-1:0];
            REG_ORIGIN_X:   cfg_in.origin_x   = csr_ch.data[COORD_W-1:0];
            REG_ORIGIN_Y:   cfg_in.origin_y   = csr_ch.data[COORD_W-1:0];
            REG_DRAW_COLOR: cfg_in.draw_color = csr_ch.data[COLOR_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thickness  <= THICKNESS_RST;
         cfg_ff.origin_x   <= ORIGIN_X_RST;
         cfg_ff.origin_y   <= ORIGIN_Y_RST;
         cfg_ff.draw_color <= DRAW_COLOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_word  (q_word)
   );

   tcr_back #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_word  (q_word),
      .cfg     (cfg_ff),
      .rsp_ch  (rsp_ch)
   );

endmodule
